@@ src/imu_average_and_frame_rotation_assert.svh @@
// Assertion macros shared by the IMU average and rotation checker
`ifndef IMU_AVERAGE_AND_FRAME_ROTATION_ASSERT_SVH
`define IMU_AVERAGE_AND_FRAME_ROTATION_ASSERT_SVH

// same-cycle implication
`define IMU_AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu_avg: assertion failed");

// next-cycle implication
`define IMU_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu_avg: assertion failed");

`endif

@@ src/imu_avg_pkg.sv @@
// Types, codes and index helpers for the IMU average and rotation block
package imu_avg_pkg;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value_0;
        logic signed [31:0] value_1;
        logic signed [31:0] value_2;
        logic signed [31:0] value_3;
        logic signed [31:0] value_4;
        logic signed [31:0] value_5;
        logic signed [31:0] value_6;
        logic signed [31:0] value_7;
        logic signed [31:0] value_8;
    } sample_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic signed [31:0] out_4;
        logic signed [31:0] out_5;
        logic signed [31:0] out_6;
        logic signed [31:0] out_7;
        logic signed [31:0] out_8;
        logic               cov_passed;
    } result_t;

    localparam logic [1:0] OP_ACC  = 2'd0;
    localparam logic [1:0] OP_EMIT = 2'd1;
    localparam logic [1:0] OP_COV  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic KIND_AVG = 1'b0;
    localparam logic KIND_COV = 1'b1;

    localparam logic [2:0] REG_QUAT_W = 3'd0;
    localparam logic [2:0] REG_QUAT_X = 3'd1;
    localparam logic [2:0] REG_QUAT_Y = 3'd2;
    localparam logic [2:0] REG_QUAT_Z = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    // dividend magnitude bits of the serial divider
    localparam int DIV_N = 50;

    localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;
    localparam logic signed [17:0] MAT_ONE      = 18'sd65536;

    function automatic logic [1:0] div3(input logic [3:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3(input logic [3:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] ix(input logic [1:0] r, input logic [1:0] c);
        return 4'(4'(r) * 4'd3 + 4'(c));
    endfunction

    // quaternion product order: ww xx yy zz xy wz xz wy yz wx
    function automatic logic [1:0] qa(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0, 4'd5, 4'd7, 4'd9: r = 2'd0;
            4'd1, 4'd4, 4'd6:       r = 2'd1;
            4'd2, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] qb(input logic [3:0] j);
        logic [1:0] r;
        case (j)
            4'd0:             r = 2'd0;
            4'd1, 4'd9:       r = 2'd1;
            4'd2, 4'd4, 4'd7: r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ src/imu_average_and_frame_rotation.sv @@
// IMU sample averaging, vector rotation and covariance rotation by a quaternion matrix
// Accumulate: never busy, one transfer per cycle while idle. Emit: decode, six serial averaging divides, vector
// multiplies, output; covariance: decode, two matrix multiply passes, output; pass-through: decode, output. A
// quaternion write adds a rebuild (products, nine divides) to the next request; a zero norm skips the divides
// and invalidates the matrix, so requests give no result. Output waits while an earlier result is still stalled
// in the result register. Reset (rst_n, async, low): identity matrix, sums and count cleared, no result pending.
module imu_average_and_frame_rotation #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  imu_avg_pkg::sample_t  sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output imu_avg_pkg::result_t  result
);
    import imu_avg_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 32 + CNT_W;
    localparam int NUM_W = DIV_N + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_POST = 9'b000000010,
        S_QMUL = 9'b000000100,
        S_QDIV = 9'b000001000,
        S_AVG  = 9'b000010000,
        S_VMUL = 9'b000100000,
        S_TMUL = 9'b001000000,
        S_RMUL = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] e_reg, e_next;
    logic [1:0] t_reg, t_next;
    logic       ph_reg, ph_next;
    logic [5:0] dcnt_reg, dcnt_next;
    logic [1:0] op_reg, op_next;

    logic signed [15:0] quat_reg [4];
    logic signed [15:0] quat_next [4];
    logic dirty_reg, dirty_next, mvalid_reg, mvalid_next;
    logic signed [17:0] mat_reg [9];
    logic signed [17:0] mat_next [9];
    logic signed [SUM_W-1:0] sum_reg [6];
    logic signed [SUM_W-1:0] sum_next [6];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [31:0] v_reg [9];
    logic signed [31:0] v_next [9];
    logic signed [31:0] pq_reg [10];
    logic signed [31:0] pq_next [10];
    logic signed [33:0] w_reg [9];
    logic signed [33:0] w_next [9];
    logic signed [31:0] res_reg [9];
    logic signed [31:0] res_next [9];
    logic rkind_reg, rkind_next, rpass_reg, rpass_next;
    logic signed [51:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [32:0] rem_reg, rem_next, den_reg, den_next;
    logic [DIV_N-1:0] quo_reg, quo_next;
    logic dneg_reg, dneg_next;
    result_t out_reg, out_next;
    logic ovalid_reg, ovalid_next;

    logic signed [31:0] sv [9];
    logic signed [34:0] p35 [10];
    logic [32:0] n2;
    logic signed [34:0] qnum;
    logic signed [NUM_W-1:0] dsrc;
    logic [32:0] dden;
    logic [NUM_W-1:0] dmag;
    logic [DIV_N-1:0] dividend;
    logic [33:0] dt;
    logic dge;
    logic [32:0] drem;
    logic [DIV_N-1:0] dquo;
    logic signed [NUM_W-1:0] dres;
    logic [1:0] er, ec;
    logic signed [33:0] ma;
    logic signed [17:0] mb;
    logic signed [51:0] mprod, macc;
    logic [51:0] mmag;
    logic [35:0] mq;
    logic signed [36:0] mr;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = ovalid_reg;
    assign result       = out_reg;

    assign sv[0] = sample.value_0;
    assign sv[1] = sample.value_1;
    assign sv[2] = sample.value_2;
    assign sv[3] = sample.value_3;
    assign sv[4] = sample.value_4;
    assign sv[5] = sample.value_5;
    assign sv[6] = sample.value_6;
    assign sv[7] = sample.value_7;
    assign sv[8] = sample.value_8;

    // matrix numerators from the stored quaternion products
    always_comb
    begin
        for (int j = 0; j < 10; j++)
            p35[j] = 35'(pq_reg[j]);
        n2 = 33'($unsigned(pq_reg[0])) + 33'($unsigned(pq_reg[1]))
           + 33'($unsigned(pq_reg[2])) + 33'($unsigned(pq_reg[3]));
        case (e_reg)
            4'd0:    qnum = p35[0] + p35[1] - p35[2] - p35[3];
            4'd1:    qnum = (p35[4] - p35[5]) <<< 1;
            4'd2:    qnum = (p35[6] + p35[7]) <<< 1;
            4'd3:    qnum = (p35[4] + p35[5]) <<< 1;
            4'd4:    qnum = p35[0] - p35[1] + p35[2] - p35[3];
            4'd5:    qnum = (p35[8] - p35[9]) <<< 1;
            4'd6:    qnum = (p35[6] - p35[7]) <<< 1;
            4'd7:    qnum = (p35[8] + p35[9]) <<< 1;
            default: qnum = p35[0] - p35[1] - p35[2] + p35[3];
        endcase
    end

    // serial restoring divider, rounding half away from zero by a pre-added half divisor
    always_comb
    begin
        if (state_reg == S_QDIV)
        begin
            dsrc = NUM_W'(qnum) <<< 16;
            dden = n2;
        end
        else
        begin
            dsrc = NUM_W'(sum_reg[e_reg[2:0]]);
            dden = 33'(cnt_reg);
        end
        dmag     = dsrc[NUM_W-1] ? NUM_W'(-dsrc) : NUM_W'(dsrc);
        dividend = dmag[DIV_N-1:0] + DIV_N'(dden >> 1);
        dt       = {rem_reg, quo_reg[DIV_N-1]};
        dge      = (dt >= {1'b0, den_reg});
        drem     = dge ? 33'(dt - {1'b0, den_reg}) : dt[32:0];
        dquo     = {quo_reg[DIV_N-2:0], dge};
        dres     = dneg_reg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
    end

    // shared multiplier operand select and accumulate with rounding
    always_comb
    begin
        er = div3(e_reg);
        ec = mod3(e_reg);
        case (state_reg)
            S_QMUL:
            begin
                ma = 34'(quat_reg[qa(e_reg)]);
                mb = 18'(quat_reg[qb(e_reg)]);
            end
            S_VMUL:
            begin
                ma = w_reg[ix(er, t_reg)];
                mb = mat_reg[ix(ec, t_reg)];
            end
            S_TMUL:
            begin
                ma = 34'(v_reg[ix(er, t_reg)]);
                mb = mat_reg[ix(ec, t_reg)];
            end
            S_RMUL:
            begin
                ma = w_reg[ix(t_reg, ec)];
                mb = mat_reg[ix(er, t_reg)];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        mprod = ma * mb;
        macc  = ((t_reg == 2'd0) ? 52'sd0 : acc_reg) + prod_reg;
        mmag  = macc[51] ? 52'(-macc) : 52'(macc);
        mq    = 36'((mmag + 52'd32768) >> 16);
        mr    = macc[51] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
    end

    always_comb
    begin
        state_next  = state_reg;
        e_next      = e_reg;
        t_next      = t_reg;
        ph_next     = ph_reg;
        dcnt_next   = dcnt_reg;
        op_next     = op_reg;
        quat_next   = quat_reg;
        dirty_next  = dirty_reg;
        mvalid_next = mvalid_reg;
        mat_next    = mat_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        v_next      = v_reg;
        pq_next     = pq_reg;
        w_next      = w_reg;
        res_next    = res_reg;
        rkind_next  = rkind_reg;
        rpass_next  = rpass_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        dneg_next   = dneg_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;

        if (cfg_we && cfg_index < REG_COUNT)
        begin
            quat_next[cfg_index[1:0]] = cfg_data;
            dirty_next = 1'b1;
        end

        if (ovalid_reg && !result_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    v_next  = sv;
                    op_next = sample.operation;
                    if ((sample.operation == OP_ACC || sample.operation == OP_EMIT)
                        && cnt_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        for (int k = 0; k < 6; k++)
                            sum_next[k] = sum_reg[k] + SUM_W'(sv[k]);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (sample.operation == OP_EMIT || sample.operation == OP_COV)
                    begin
                        state_next = dirty_reg ? S_QMUL : S_POST;
                        e_next     = '0;
                        t_next     = '0;
                        ph_next    = 1'b0;
                        dcnt_next  = '0;
                    end
                end
            end
            S_QMUL:
            begin
                if (!ph_reg)
                begin
                    prod_next = mprod;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next         = 1'b0;
                    pq_next[e_reg]  = prod_reg[31:0];
                    if (e_reg == 4'd9)
                    begin
                        e_next     = '0;
                        state_next = S_QDIV;
                    end
                    else
                        e_next = e_reg + 1'b1;
                end
            end
            S_QDIV:
            begin
                if (dcnt_reg == '0)
                begin
                    if (n2 == '0)
                    begin
                        mvalid_next = 1'b0;
                        dirty_next  = 1'b0;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        rem_next  = '0;
                        quo_next  = dividend;
                        den_next  = dden;
                        dneg_next = dsrc[NUM_W-1];
                        dcnt_next = 6'd1;
                    end
                end
                else
                begin
                    rem_next = drem;
                    quo_next = dquo;
                    if (dcnt_reg == 6'(DIV_N))
                    begin
                        mat_next[e_reg] = dres[17:0];
                        dcnt_next       = '0;
                        if (e_reg == 4'd8)
                        begin
                            e_next      = '0;
                            mvalid_next = 1'b1;
                            dirty_next  = 1'b0;
                            state_next  = S_POST;
                        end
                        else
                            e_next = e_reg + 1'b1;
                    end
                    else
                        dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_POST:
            begin
                e_next    = '0;
                t_next    = '0;
                ph_next   = 1'b0;
                dcnt_next = '0;
                case (op_reg)
                    OP_EMIT: state_next = S_AVG;
                    OP_COV:
                    begin
                        if (!mvalid_reg)
                            state_next = S_IDLE;
                        else if (v_reg[0][31])
                        begin
                            res_next   = v_reg;
                            rkind_next = KIND_COV;
                            rpass_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_TMUL;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_AVG:
            begin
                if (dcnt_reg == '0)
                begin
                    rem_next  = '0;
                    quo_next  = dividend;
                    den_next  = dden;
                    dneg_next = dsrc[NUM_W-1];
                    dcnt_next = 6'd1;
                end
                else
                begin
                    rem_next = drem;
                    quo_next = dquo;
                    if (dcnt_reg == 6'(DIV_N))
                    begin
                        w_next[e_reg] = dres[33:0];
                        dcnt_next     = '0;
                        if (e_reg == 4'd5)
                        begin
                            for (int k = 0; k < 6; k++)
                                sum_next[k] = '0;
                            cnt_next   = '0;
                            e_next     = '0;
                            state_next = mvalid_reg ? S_VMUL : S_IDLE;
                        end
                        else
                            e_next = e_reg + 1'b1;
                    end
                    else
                        dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_VMUL, S_TMUL, S_RMUL:
            begin
                if (!ph_reg)
                begin
                    prod_next = mprod;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next  = 1'b0;
                    acc_next = macc;
                    if (t_reg == 2'd2)
                    begin
                        t_next = '0;
                        e_next = e_reg + 1'b1;
                        if (state_reg == S_TMUL)
                        begin
                            w_next[e_reg] = mr[33:0];
                            if (e_reg == 4'd8)
                            begin
                                e_next     = '0;
                                state_next = S_RMUL;
                            end
                        end
                        else
                        begin
                            res_next[e_reg] = sat32(mr);
                            if (state_reg == S_VMUL && e_reg == 4'd5)
                            begin
                                res_next[6] = '0;
                                res_next[7] = '0;
                                res_next[8] = '0;
                                rkind_next  = KIND_AVG;
                                rpass_next  = 1'b0;
                                state_next  = S_OUT;
                            end
                            else if (state_reg == S_RMUL && e_reg == 4'd8)
                            begin
                                rkind_next = KIND_COV;
                                rpass_next = 1'b0;
                                state_next = S_OUT;
                            end
                        end
                    end
                    else
                        t_next = t_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || !result_stall)
                begin
                    out_next.kind       = rkind_reg;
                    out_next.out_0      = res_reg[0];
                    out_next.out_1      = res_reg[1];
                    out_next.out_2      = res_reg[2];
                    out_next.out_3      = res_reg[3];
                    out_next.out_4      = res_reg[4];
                    out_next.out_5      = res_reg[5];
                    out_next.out_6      = res_reg[6];
                    out_next.out_7      = res_reg[7];
                    out_next.out_8      = res_reg[8];
                    out_next.cov_passed = rpass_reg;
                    ovalid_next         = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            e_reg      <= '0;
            t_reg      <= '0;
            ph_reg     <= 1'b0;
            dcnt_reg   <= '0;
            quat_reg[REG_QUAT_W[1:0]] <= QUAT_W_RESET;
            quat_reg[REG_QUAT_X[1:0]] <= '0;
            quat_reg[REG_QUAT_Y[1:0]] <= '0;
            quat_reg[REG_QUAT_Z[1:0]] <= '0;
            dirty_reg  <= 1'b0;
            mvalid_reg <= 1'b1;
            for (int k = 0; k < 9; k++)
                mat_reg[k] <= (k % 4 == 0) ? MAT_ONE : '0;
            for (int k = 0; k < 6; k++)
                sum_reg[k] <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            e_reg      <= e_next;
            t_reg      <= t_next;
            ph_reg     <= ph_next;
            dcnt_reg   <= dcnt_next;
            quat_reg   <= quat_next;
            dirty_reg  <= dirty_next;
            mvalid_reg <= mvalid_next;
            mat_reg    <= mat_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        v_reg     <= v_next;
        pq_reg    <= pq_next;
        w_reg     <= w_next;
        res_reg   <= res_next;
        rkind_reg <= rkind_next;
        rpass_reg <= rpass_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        dneg_reg  <= dneg_next;
        out_reg   <= out_next;
    end

endmodule

@@ src/imu_avg_checker.sv @@
// Port-level assertions for the IMU average and rotation block, bound to the top level
`include "imu_average_and_frame_rotation_assert.svh"

module imu_avg_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sample_valid,
    input logic                 sample_stall,
    input imu_avg_pkg::sample_t sample,
    input logic                 result_valid,
    input logic                 result_stall,
    input imu_avg_pkg::result_t result
);
    import imu_avg_pkg::*;

    logic in_xfer;
    logic req_xfer;
    logic tail_clear;
    assign in_xfer    = sample_valid && !sample_stall;
    assign req_xfer   = in_xfer && (sample.operation == OP_EMIT || sample.operation == OP_COV);
    assign tail_clear = result.out_6 == '0 && result.out_7 == '0 && result.out_8 == '0
                        && !result.cov_passed;

    `IMU_AST_NEXT(a_result_held, result_valid && result_stall, result_valid)
    `IMU_AST_NEXT(a_acc_no_busy, in_xfer && sample.operation == OP_ACC, !sample_stall)
    `IMU_AST_NEXT(a_req_busy, req_xfer, sample_stall)
    `IMU_AST_IMPLY(a_avg_tail, result_valid && result.kind == KIND_AVG, tail_clear)

endmodule

bind imu_average_and_frame_rotation imu_avg_checker u_imu_avg_checker (.*);
